// File: hdl/lbm_d2q9_bgk_node_collision_assert.svh
// ---------------------------------------------------------------------------
// LBM collision assertion macros
// Shared property forms for the collision block; expects clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef LBM_D2Q9_BGK_NODE_COLLISION_ASSERT_SVH
`define LBM_D2Q9_BGK_NODE_COLLISION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LBMC_AP_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbmc: implication check failed");

// condition must never hold
`define LBMC_AP_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("lbmc: forbidden condition seen");

`endif

// File: hdl/lbmc_pkg.sv
// ---------------------------------------------------------------------------
// LBM collision package
// Types and fixed constants for the D2Q9 BGK node collision block.
// ---------------------------------------------------------------------------
package lbmc_pkg;

	localparam int W        = 24;
	localparam int RW       = 28;
	localparam int QB       = 24;
	localparam int DIV_LAT  = QB + 2;
	localparam int LANE_LAT = 14;
	localparam int NDIR     = 9;
	localparam int TAU_W    = 17;
	localparam int TAU_FRAC = 16;
	localparam int USQ_W    = 48;
	localparam int POLY_W   = 36;
	localparam int FEQ_SH   = 40;
	localparam int FEQ_W    = 42;
	localparam int CHUNK    = 8;
	localparam int NCHUNK   = 6;
	localparam int DVW      = CHUNK * NCHUNK;
	localparam int DIV_C    = 36;
	localparam int RECIP_C  = 29128;
	localparam int RECIP_SH = 20;
	localparam int TAU_RST  = 65536;
	localparam longint POLY_LIM = 64'sd34359738367;

	localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
	localparam int WT_SH [NDIR] = '{4, 2, 2, 2, 2, 0, 0, 0, 0};

	typedef logic signed [W-1:0] fx_t;
	typedef fx_t [NDIR-1:0] fvec_t;

	typedef struct packed {
		fx_t f_rest;
		fx_t f_east;
		fx_t f_north;
		fx_t f_west;
		fx_t f_south;
		fx_t f_northeast;
		fx_t f_northwest;
		fx_t f_southwest;
		fx_t f_southeast;
	} node_t;

	typedef struct packed {
		fx_t post_rest;
		fx_t post_east;
		fx_t post_north;
		fx_t post_west;
		fx_t post_south;
		fx_t post_northeast;
		fx_t post_northwest;
		fx_t post_southwest;
		fx_t post_southeast;
		fx_t density;
		fx_t velocity_x;
		fx_t velocity_y;
	} result_t;

	function automatic fvec_t node_to_vec(node_t n);
		fvec_t v;
		v[0] = n.f_rest;
		v[1] = n.f_east;
		v[2] = n.f_north;
		v[3] = n.f_west;
		v[4] = n.f_south;
		v[5] = n.f_northeast;
		v[6] = n.f_northwest;
		v[7] = n.f_southwest;
		v[8] = n.f_southeast;
		return v;
	endfunction

endpackage

// File: hdl/lbmc_div.sv
// ---------------------------------------------------------------------------
// LBM collision velocity divider
// Pipelined restoring divide: momentum * 2^FRAC_BITS / density, one quotient
// bit per stage, truncated toward zero, saturated, zero below density floor.
// ---------------------------------------------------------------------------
module lbmc_div #(
	parameter int FRAC_BITS = 20
) (
	input  logic                              clk,
	input  logic signed [lbmc_pkg::RW-1:0]    mom,
	input  logic signed [lbmc_pkg::RW-1:0]    rho,
	output lbmc_pkg::fx_t                     vel
);
	localparam int RW = lbmc_pkg::RW;
	localparam int QB = lbmc_pkg::QB;
	localparam int FB = FRAC_BITS;
	localparam int NW = RW + FB;
	localparam int CW = ((NW > RW + QB) ? NW : RW + QB) + 1;
	localparam longint FLOOR_RAW = ((longint'(1) << FB) + 500000) / 1000000;
	localparam longint FLOOR = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;
	localparam logic [QB-1:0] QPOS_MAX = {1'b0, {(QB-1){1'b1}}};
	localparam logic [QB-1:0] QNEG_MAX = {1'b1, {(QB-1){1'b0}}};

	logic [CW-1:0] rem_s [0:QB];
	logic [RW-1:0] den_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic          neg_s [0:QB];
	logic          ok_s  [0:QB];
	logic          ovf_s [0:QB];
	lbmc_pkg::fx_t vel_q;

	logic [RW-1:0] mag;
	logic [CW-1:0] num;

	always_comb begin
		mag = mom[RW-1] ? RW'(-mom) : RW'(mom);
		num = CW'(mag) << FB;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= rho;
		quo_s[0] <= '0;
		neg_s[0] <= mom[RW-1];
		ok_s[0]  <= (rho >= $signed(RW'(FLOOR)));
		ovf_s[0] <= (num >= (CW'(rho) << QB));
	end

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic [CW-1:0] trial;
		assign trial = CW'(den_s[j]) << (QB - 1 - j);
		always_ff @(posedge clk) begin
			if (rem_s[j] >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial;
				quo_s[j+1] <= quo_s[j] | (QB'(1) << (QB - 1 - j));
			end else begin
				rem_s[j+1] <= rem_s[j];
				quo_s[j+1] <= quo_s[j];
			end
			den_s[j+1] <= den_s[j];
			neg_s[j+1] <= neg_s[j];
			ok_s[j+1]  <= ok_s[j];
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (!ok_s[QB]) begin
			vel_q <= '0;
		end else if (neg_s[QB]) begin
			if (ovf_s[QB] || quo_s[QB] > QNEG_MAX)
				vel_q <= $signed(QNEG_MAX);
			else
				vel_q <= $signed(-quo_s[QB]);
		end else begin
			if (ovf_s[QB] || quo_s[QB] > QPOS_MAX)
				vel_q <= $signed(QPOS_MAX);
			else
				vel_q <= $signed(quo_s[QB]);
		end
	end

	assign vel = vel_q;

endmodule

// File: hdl/lbmc_lane.sv
// ---------------------------------------------------------------------------
// LBM collision direction lane
// Equilibrium polynomial, density product, weight/36 and BGK relaxation for
// one lattice direction, fully pipelined.
// ---------------------------------------------------------------------------
module lbmc_lane #(
	parameter int FRAC_BITS = 20,
	parameter int DIR       = 0
) (
	input  logic                                 clk,
	input  lbmc_pkg::fx_t                        ux,
	input  lbmc_pkg::fx_t                        uy,
	input  logic [lbmc_pkg::USQ_W-1:0]           usq,
	input  logic signed [lbmc_pkg::RW-1:0]       rho,
	input  lbmc_pkg::fx_t                        f,
	input  logic [lbmc_pkg::TAU_W-1:0]           inv_tau,
	output lbmc_pkg::fx_t                        post
);
	localparam int FB  = FRAC_BITS;
	localparam int RW  = lbmc_pkg::RW;
	localparam int DX  = lbmc_pkg::DIR_X[DIR];
	localparam int DY  = lbmc_pkg::DIR_Y[DIR];
	localparam int SH  = lbmc_pkg::WT_SH[DIR];
	localparam int PW  = ((2 * FB + 2 > 53) ? 2 * FB + 2 : 53) + 3;
	localparam int SW  = 65;
	localparam int XW  = SW - FB;
	localparam int YW  = (XW + 4 > 47) ? XW + 4 : 47;
	localparam int DVW = lbmc_pkg::DVW;
	localparam int CK  = lbmc_pkg::CHUNK;
	localparam int NC  = lbmc_pkg::NCHUNK;
	localparam int PLW = lbmc_pkg::POLY_W;
	localparam int FW  = lbmc_pkg::FEQ_W;
	localparam int FDL = lbmc_pkg::LANE_LAT - 1;
	localparam int MW  = 2 * CK + 13;

	// f travels alongside the datapath
	lbmc_pkg::fx_t fd_q [0:FDL-1];

	always_ff @(posedge clk) begin
		fd_q[0] <= f;
		for (int i = 1; i < FDL; i++)
			fd_q[i] <= fd_q[i-1];
	end

	// stage 1: projected velocity and its square
	logic signed [25:0] cx, cy, cu;
	logic signed [25:0] cu_s1;
	logic signed [51:0] cusq_s1;
	logic [lbmc_pkg::USQ_W-1:0] usq_s1;
	logic signed [RW-1:0] rho_s1;

	always_comb begin
		cx = '0;
		cy = '0;
		if (DX == 1)
			cx = 26'(ux);
		else if (DX == -1)
			cx = -26'(ux);
		if (DY == 1)
			cy = 26'(uy);
		else if (DY == -1)
			cy = -26'(uy);
		cu = cx + cy;
	end

	always_ff @(posedge clk) begin
		cu_s1   <= cu;
		cusq_s1 <= cu * cu;
		usq_s1  <= usq;
		rho_s1  <= rho;
	end

	// stage 2: polynomial, rounded and limited
	logic signed [PW-1:0] one2, t_usq, t_cu, t_sq, poly2, pr;
	logic signed [PLW-1:0] poly_s2;
	logic signed [RW-1:0] rho_s2;

	always_comb begin
		one2  = PW'(1) <<< (2 * FB + 1);
		t_usq = $signed(PW'(usq_s1));
		t_cu  = PW'(cu_s1) <<< FB;
		t_sq  = PW'(cusq_s1);
		poly2 = one2 - ((t_usq <<< 1) + t_usq) + ((t_cu <<< 2) + (t_cu <<< 1))
			+ ((t_sq <<< 3) + t_sq);
		pr = (poly2 + (PW'(1) <<< FB)) >>> (FB + 1);
	end

	always_ff @(posedge clk) begin
		if (pr > PW'(lbmc_pkg::POLY_LIM))
			poly_s2 <= PLW'(lbmc_pkg::POLY_LIM);
		else if (pr < -PW'(lbmc_pkg::POLY_LIM))
			poly_s2 <= -PLW'(lbmc_pkg::POLY_LIM);
		else
			poly_s2 <= pr[PLW-1:0];
		rho_s2 <= rho_s1;
	end

	// stage 3: density times polynomial as two partial products
	logic signed [45:0] pph_s3;
	logic signed [46:0] ppl_s3;

	always_ff @(posedge clk) begin
		pph_s3 <= rho_s2 * $signed(poly_s2[PLW-1:18]);
		ppl_s3 <= rho_s2 * $signed({1'b0, poly_s2[17:0]});
	end

	// stage 4: combine and round
	logic signed [SW-1:0] psum, xr;
	logic signed [XW-1:0] x_s4;

	always_comb begin
		psum = (SW'(pph_s3) <<< 18) + SW'(ppl_s3);
		xr   = (psum + (SW'(1) <<< (FB - 1))) >>> FB;
	end

	always_ff @(posedge clk)
		x_s4 <= xr[XW-1:0];

	// stage 5: weight, magnitude, limit detect
	logic [XW-1:0] ax;
	logic [YW-1:0] yv;

	always_comb begin
		ax = x_s4[XW-1] ? XW'(-x_s4) : XW'(x_s4);
		yv = YW'(ax) << SH;
	end

	logic [DVW-1:0] dv_s  [0:NC];
	logic [DVW-1:0] quo_s [0:NC];
	logic [5:0]     rem_s [0:NC];
	logic           neg_s [0:NC];
	logic           sat_s [0:NC];

	always_ff @(posedge clk) begin
		dv_s[0]  <= DVW'(yv);
		quo_s[0] <= '0;
		rem_s[0] <= '0;
		neg_s[0] <= x_s4[XW-1];
		sat_s[0] <= (yv >= (YW'(lbmc_pkg::DIV_C) << lbmc_pkg::FEQ_SH));
	end

	// divide by 36, one byte per stage via reciprocal multiply
	for (genvar c = 0; c < NC; c++) begin : g_chunk
		logic [CK+5:0] cur;
		logic [MW-1:0] mq;
		logic [CK-1:0] qb;
		logic [CK+5:0] rm;
		always_comb begin
			cur = {rem_s[c], dv_s[c][DVW-1-CK*c -: CK]};
			mq  = MW'(cur) * MW'(lbmc_pkg::RECIP_C);
			qb  = mq[lbmc_pkg::RECIP_SH +: CK];
			rm  = cur - (CK+6)'(qb) * (CK+6)'(lbmc_pkg::DIV_C);
		end
		always_ff @(posedge clk) begin
			dv_s[c+1]  <= dv_s[c];
			quo_s[c+1] <= {quo_s[c][DVW-CK-1:0], qb};
			rem_s[c+1] <= rm[5:0];
			neg_s[c+1] <= neg_s[c];
			sat_s[c+1] <= sat_s[c];
		end
	end

	// relaxation
	logic [lbmc_pkg::FEQ_SH-1:0] fmag;
	logic signed [FW-1:0] feq;
	logic signed [FW:0] d_s;
	logic signed [FW+lbmc_pkg::TAU_W+1:0] prod_s;
	logic signed [FW+lbmc_pkg::TAU_W+1:0] rr, ss;
	lbmc_pkg::fx_t post_q;

	always_comb begin
		fmag = sat_s[NC] ? '1 : quo_s[NC][lbmc_pkg::FEQ_SH-1:0];
		feq  = neg_s[NC] ? -$signed({2'b00, fmag}) : $signed({2'b00, fmag});
	end

	always_ff @(posedge clk) begin
		d_s    <= (FW+1)'(feq) - (FW+1)'(fd_q[FDL-3]);
		prod_s <= d_s * $signed({1'b0, inv_tau});
	end

	always_comb begin
		rr = (prod_s + ((FW+lbmc_pkg::TAU_W+2)'(1) <<< (lbmc_pkg::TAU_FRAC - 1)))
			>>> lbmc_pkg::TAU_FRAC;
		ss = rr + (FW+lbmc_pkg::TAU_W+2)'(fd_q[FDL-1]);
	end

	always_ff @(posedge clk) begin
		if (ss > (FW+lbmc_pkg::TAU_W+2)'(8388607))
			post_q <= 24'sh7FFFFF;
		else if (ss < -(FW+lbmc_pkg::TAU_W+2)'(8388608))
			post_q <= 24'sh800000;
		else
			post_q <= ss[lbmc_pkg::W-1:0];
	end

	assign post = post_q;

endmodule

// File: hdl/lbm_d2q9_bgk_node_collision.sv
// ---------------------------------------------------------------------------
// D2Q9 BGK node collision
// Nine streamed distributions in, nine post-collision distributions plus
// density and velocity out.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive cmd and pulse start; a transaction is taken on every edge
//   with start high and busy low. busy is always low: one node per cycle.
//   Output: done is high for one cycle with result valid; a transaction
//   completes at the edge ending that cycle. The receiver cannot stall.
//   Pipeline: the accepting edge registers the sums; the velocity divider
//   follows (one quotient bit per stage, both components in parallel), then
//   the |u|^2 register, the nine direction lanes (the byte-wise divide by 36
//   among them) and the output merge register, which holds the result.
//   Throughput: one node per clock, fixed by the fully pipelined lanes.
//   Config: cfg_we writes cfg_wdata into 1/tau; only while no transaction
//   is in flight. Reset sets 1/tau to 1.0 and clears all in-flight valids.
// ---------------------------------------------------------------------------
module lbm_d2q9_bgk_node_collision #(
	parameter int FRAC_BITS = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  lbmc_pkg::node_t                 cmd,
	output logic                            done,
	output lbmc_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [lbmc_pkg::TAU_W-1:0]      cfg_wdata
);
	localparam int RW   = lbmc_pkg::RW;
	localparam int ND   = lbmc_pkg::NDIR;
	localparam int DL   = lbmc_pkg::DIV_LAT;
	localparam int LL   = lbmc_pkg::LANE_LAT;
	localparam int LAT  = DL + LL + 3;
	localparam longint FLOOR_RAW = ((longint'(1) << FRAC_BITS) + 500000) / 1000000;
	localparam longint FLOOR = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;

	logic [lbmc_pkg::TAU_W-1:0] inv_tau_q;
	logic [LAT-1:0] vld_q;
	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tau_q <= lbmc_pkg::TAU_W'(lbmc_pkg::TAU_RST);
			vld_q     <= '0;
		end else begin
			if (cfg_we)
				inv_tau_q <= cfg_wdata;
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// stage 1: sums
	lbmc_pkg::fvec_t fin;
	logic signed [RW-1:0] rho_c, mx_c, my_c;
	lbmc_pkg::fvec_t f_s1;
	logic signed [RW-1:0] rho_s1, mx_s1, my_s1;

	always_comb begin
		fin   = lbmc_pkg::node_to_vec(cmd);
		rho_c = '0;
		for (int k = 0; k < ND; k++)
			rho_c = rho_c + RW'(fin[k]);
		mx_c = RW'(fin[1]) - RW'(fin[3]) + RW'(fin[5]) - RW'(fin[6])
			- RW'(fin[7]) + RW'(fin[8]);
		my_c = RW'(fin[2]) - RW'(fin[4]) + RW'(fin[5]) + RW'(fin[6])
			- RW'(fin[7]) - RW'(fin[8]);
	end

	always_ff @(posedge clk) begin
		f_s1   <= fin;
		rho_s1 <= rho_c;
		mx_s1  <= mx_c;
		my_s1  <= my_c;
	end

	// velocity
	lbmc_pkg::fx_t ux, uy;

	lbmc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk (clk),
		.mom (mx_s1),
		.rho (rho_s1),
		.vel (ux)
	);

	lbmc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk (clk),
		.mom (my_s1),
		.rho (rho_s1),
		.vel (uy)
	);

	lbmc_pkg::fvec_t      fp_q  [0:DL-1];
	logic signed [RW-1:0] rhp_q [0:DL-1];

	always_ff @(posedge clk) begin
		fp_q[0]  <= f_s1;
		rhp_q[0] <= rho_s1;
		for (int i = 1; i < DL; i++) begin
			fp_q[i]  <= fp_q[i-1];
			rhp_q[i] <= rhp_q[i-1];
		end
	end

	// shared |u|^2 stage
	lbmc_pkg::fvec_t f_e1;
	logic signed [RW-1:0] rho_e1;
	lbmc_pkg::fx_t ux_e1, uy_e1;
	logic [lbmc_pkg::USQ_W-1:0] usq_e1;
	logic signed [47:0] sqx, sqy;

	always_comb begin
		sqx = ux * ux;
		sqy = uy * uy;
	end

	always_ff @(posedge clk) begin
		f_e1   <= fp_q[DL-1];
		rho_e1 <= rhp_q[DL-1];
		ux_e1  <= ux;
		uy_e1  <= uy;
		usq_e1 <= lbmc_pkg::USQ_W'(sqx) + lbmc_pkg::USQ_W'(sqy);
	end

	// direction lanes
	lbmc_pkg::fvec_t post;

	for (genvar k = 0; k < ND; k++) begin : g_lane
		lbmc_lane #(.FRAC_BITS(FRAC_BITS), .DIR(k)) u_lane (
			.clk     (clk),
			.ux      (ux_e1),
			.uy      (uy_e1),
			.usq     (usq_e1),
			.rho     (rho_e1),
			.f       (f_e1[k]),
			.inv_tau (inv_tau_q),
			.post    (post[k])
		);
	end

	// side data alongside lanes
	lbmc_pkg::fx_t dens_c;
	lbmc_pkg::fx_t dens_q [0:LL-1];
	lbmc_pkg::fx_t vx_q   [0:LL-1];
	lbmc_pkg::fx_t vy_q   [0:LL-1];

	always_comb begin
		if (rho_e1 > RW'(8388607))
			dens_c = 24'sh7FFFFF;
		else if (rho_e1 < -RW'(8388608))
			dens_c = 24'sh800000;
		else
			dens_c = rho_e1[lbmc_pkg::W-1:0];
	end

	always_ff @(posedge clk) begin
		dens_q[0] <= dens_c;
		vx_q[0]   <= ux_e1;
		vy_q[0]   <= uy_e1;
		for (int i = 1; i < LL; i++) begin
			dens_q[i] <= dens_q[i-1];
			vx_q[i]   <= vx_q[i-1];
			vy_q[i]   <= vy_q[i-1];
		end
	end

	// merge
	lbmc_pkg::result_t res_q;

	always_ff @(posedge clk) begin
		res_q.post_rest      <= post[0];
		res_q.post_east      <= post[1];
		res_q.post_north     <= post[2];
		res_q.post_west      <= post[3];
		res_q.post_south     <= post[4];
		res_q.post_northeast <= post[5];
		res_q.post_northwest <= post[6];
		res_q.post_southwest <= post[7];
		res_q.post_southeast <= post[8];
		res_q.density        <= dens_q[LL-1];
		res_q.velocity_x     <= vx_q[LL-1];
		res_q.velocity_y     <= vy_q[LL-1];
	end

	assign result = res_q;
	assign done   = vld_q[LAT-1];

`include "lbm_d2q9_bgk_node_collision_assert.svh"

	`LBMC_AP_IMPL(a_done_src, done, $past(accept, LAT))
	`LBMC_AP_NEVER(a_floor_vel, done && (result.density < $signed(24'(FLOOR)))
		&& (result.velocity_x != '0 || result.velocity_y != '0))
	`LBMC_AP_IMPL(a_zero_node, done && $past(accept && cmd == '0, LAT), result == '0)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// D2Q9 BGK node collision testbench
// Drives nodes through the command port and checks every result, field by
// field, against an in-bench fixed-point predictor of the collision.
// ---------------------------------------------------------------------------
module tb;

	localparam int FB = 20;
	localparam int LAT = 43;
	localparam longint OMAX = 64'sd8388607;
	localparam longint OMIN = -64'sd8388608;
	localparam longint PLIM = 64'sd34359738367;
	localparam longint FLIM = 64'sd1099511627775;
	localparam longint WT [9] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lbmc_pkg::node_t cmd;
	logic done;
	lbmc_pkg::result_t result;
	logic cfg_we;
	logic [lbmc_pkg::TAU_W-1:0] cfg_wdata;

	logic [lbmc_pkg::TAU_W-1:0] tau_shadow;
	lbmc_pkg::result_t expected_q[$];
	int errors;
	bit no_idle;

	lbm_d2q9_bgk_node_collision #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb: FAIL");
		$finish;
	end

	function automatic longint clampl(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint rshift_round(longint x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic lbmc_pkg::result_t collide(lbmc_pkg::node_t n);
		longint f [9];
		longint post [9];
		longint rho, mx, my, ux, uy, usq, cu, p2, poly, feq, rel, sc, flr, dn;
		lbmc_pkg::result_t r;
		lbmc_pkg::fvec_t v;
		v = lbmc_pkg::node_to_vec(n);
		rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
		sc = 64'sd1 <<< FB;
		for (int k = 0; k < 9; k++) begin
			f[k] = longint'(v[k]);
			rho += f[k];
			mx += f[k] * lbmc_pkg::DIR_X[k];
			my += f[k] * lbmc_pkg::DIR_Y[k];
		end
		flr = (sc + 500000) / 1000000;
		if (flr < 1) flr = 1;
		if (rho >= flr) begin
			ux = clampl((mx * sc) / rho, OMIN, OMAX);
			uy = clampl((my * sc) / rho, OMIN, OMAX);
		end
		usq = ux * ux + uy * uy;
		for (int k = 0; k < 9; k++) begin
			cu = ux * lbmc_pkg::DIR_X[k] + uy * lbmc_pkg::DIR_Y[k];
			p2 = 2 * (64'sd1 <<< (2 * FB)) - 3 * usq + 6 * cu * sc + 9 * cu * cu;
			poly = clampl(rshift_round(p2, FB + 1), -PLIM, PLIM);
			feq = rshift_round(rho * poly, FB) * WT[k] / 36;
			feq = clampl(feq, -FLIM, FLIM);
			rel = rshift_round((feq - f[k]) * longint'({1'b0, tau_shadow}), 16);
			post[k] = clampl(f[k] + rel, OMIN, OMAX);
		end
		dn = clampl(rho, OMIN, OMAX);
		r.post_rest      = post[0][23:0];
		r.post_east      = post[1][23:0];
		r.post_north     = post[2][23:0];
		r.post_west      = post[3][23:0];
		r.post_south     = post[4][23:0];
		r.post_northeast = post[5][23:0];
		r.post_northwest = post[6][23:0];
		r.post_southwest = post[7][23:0];
		r.post_southeast = post[8][23:0];
		r.density        = dn[23:0];
		r.velocity_x     = ux[23:0];
		r.velocity_y     = uy[23:0];
		return r;
	endfunction

	task automatic cmp(string name, lbmc_pkg::fx_t exp_v, lbmc_pkg::fx_t act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d actual %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		lbmc_pkg::result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result: unexpected transaction");
				errors++;
			end else begin
				e = expected_q.pop_front();
				cmp("post_rest", e.post_rest, result.post_rest);
				cmp("post_east", e.post_east, result.post_east);
				cmp("post_north", e.post_north, result.post_north);
				cmp("post_west", e.post_west, result.post_west);
				cmp("post_south", e.post_south, result.post_south);
				cmp("post_northeast", e.post_northeast, result.post_northeast);
				cmp("post_northwest", e.post_northwest, result.post_northwest);
				cmp("post_southwest", e.post_southwest, result.post_southwest);
				cmp("post_southeast", e.post_southeast, result.post_southeast);
				cmp("density", e.density, result.density);
				cmp("velocity_x", e.velocity_x, result.velocity_x);
				cmp("velocity_y", e.velocity_y, result.velocity_y);
			end
		end
	end

	task automatic send_node(lbmc_pkg::node_t n);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= n;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q = {expected_q, collide(n)};
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tau(logic [lbmc_pkg::TAU_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		tau_shadow = val;
	endtask

	function automatic lbmc_pkg::node_t uniform_node(longint base, longint spread);
		lbmc_pkg::node_t n;
		lbmc_pkg::fvec_t v;
		for (int k = 0; k < 9; k++)
			v[k] = lbmc_pkg::fx_t'(base + longint'($urandom_range(0, 32'(2 * spread)))
				- spread);
		n.f_rest = v[0]; n.f_east = v[1]; n.f_north = v[2];
		n.f_west = v[3]; n.f_south = v[4]; n.f_northeast = v[5];
		n.f_northwest = v[6]; n.f_southwest = v[7]; n.f_southeast = v[8];
		return n;
	endfunction

	function automatic lbmc_pkg::node_t raw_node();
		lbmc_pkg::node_t n;
		n = lbmc_pkg::node_t'(216'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom}));
		return n;
	endfunction

	function automatic lbmc_pkg::node_t one_hot_node(int dir, lbmc_pkg::fx_t val);
		lbmc_pkg::node_t n;
		n = '0;
		case (dir)
			0: n.f_rest = val;
			1: n.f_east = val;
			2: n.f_north = val;
			3: n.f_west = val;
			4: n.f_south = val;
			5: n.f_northeast = val;
			6: n.f_northwest = val;
			7: n.f_southwest = val;
			default: n.f_southeast = val;
		endcase
		return n;
	endfunction

	task automatic test_directed();
		lbmc_pkg::node_t n;
		send_node('0);
		n = '1;
		send_node(n);
		n = {9{24'h7FFFFF}};
		send_node(n);
		n = {9{24'h800000}};
		send_node(n);
		for (int d = 0; d < 9; d++)
			send_node(one_hot_node(d, 24'sh100000));
		send_node(one_hot_node(1, 24'sd1));
		send_node(one_hot_node(0, 24'sd1));
		send_node(one_hot_node(5, 24'sh7FFFFF));
		n = one_hot_node(1, 24'sh7FFFFF);
		n.f_west = 24'sh800000;
		n.f_rest = 24'sd2;
		send_node(n);
		n = one_hot_node(2, 24'sh400000);
		n.f_south = -24'sh3FFFF0;
		send_node(n);
		send_node(uniform_node(64'sd116508, 64'sd0));
		send_node(uniform_node(-64'sd1000, 64'sd500));
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1: send_node(raw_node());
				2: send_node(uniform_node(longint'($urandom_range(0, 8)) <<< 17, 64'sd4096));
				3: send_node(uniform_node(64'sd0, 64'sd8));
				default: send_node(uniform_node(64'sd116508,
					longint'($urandom_range(0, 60000))));
			endcase
		end
		drain();
	endtask

	task automatic test_tau_settings();
		write_tau(17'd0);
		test_random(150);
		write_tau(17'h1FFFF);
		test_directed();
		test_random(150);
		write_tau(17'd32768);
		test_random(150);
		write_tau(17'd98304);
		test_random(150);
		write_tau(17'($urandom_range(0, 131071)));
		test_random(150);
		write_tau(17'd65536);
	endtask

	initial begin
		errors = 0;
		no_idle = 0;
		tau_shadow = lbmc_pkg::TAU_W'(lbmc_pkg::TAU_RST);
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1000);
		test_tau_settings();
		no_idle = 1;
		test_random(250);
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
